>>> hw/rtl/gri_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Gyro rate integrator package
// Shared widths, register indexes, reset values and structure types.
// ----------------------------------------------------------------------------
package gri_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 17;
    localparam int GAIN_W     = 24;
    localparam int FRAC_W     = 24;
    localparam int ANGLE_W    = 40;
    localparam int DEADBAND_W = 8;
    localparam int STEP_W     = 5;
    localparam int LEVEL_W    = 4;
    localparam int LEVELS     = 8;
    localparam int LED_W      = LEVELS + 1;
    localparam int ABS_HI_W   = ANGLE_W - FRAC_W;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_DEPTH  = 8;

    localparam logic                  RST_DISPLAY_ENABLE = 1'b0;
    localparam logic [DEADBAND_W-1:0] RST_DEADBAND       = 8'd10;
    localparam logic [GAIN_W-1:0]     RST_STEP_GAIN      = 24'd23488;
    localparam logic [STEP_W-1:0]     RST_LEVEL_STEP     = 5'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISPLAY_ENABLE = 2'd0,
        CFG_DEADBAND       = 2'd1,
        CFG_STEP_GAIN      = 2'd2,
        CFG_LEVEL_STEP     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                  display_enable;
        logic [DEADBAND_W-1:0] deadband;
        logic [GAIN_W-1:0]     step_gain;
        logic [STEP_W-1:0]     level_step;
    } cfg_t;

    // Packed so that the angle sits in the lowest bits.
    typedef struct packed {
        logic [LED_W-1:0]   led_bar;
        logic [LEVEL_W-1:0] bar_level;
        logic [ANGLE_W-1:0] angle;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage
`default_nettype wire

>>> hw/rtl/gri_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Gyro rate integrator datapath
// Deadband, gain product, saturating accumulator and LED bar update.
// ----------------------------------------------------------------------------
module gri_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire gri_pkg::cfg_t   cfg,
    input  wire logic            in_valid,
    input  wire logic [15:0]     in_sample,
    output logic                 out_valid,
    output gri_pkg::result_t     out_result
);
    import gri_pkg::*;

    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

    // Stage A: sample register.
    logic                valid_a_reg;
    logic [SAMPLE_W-1:0] sample_a_reg;

    // Stage B: signed product.
    logic               valid_b_reg;
    logic               neg_b_reg;
    logic [ANGLE_W-1:0] delta_b_reg;

    // Stage C: accumulator.
    logic                      valid_c_reg;
    logic signed [ANGLE_W-1:0] acc_reg;
    logic signed [ANGLE_W-1:0] acc_next;

    // Stage D: snapshot of the angle and its magnitude in whole degrees.
    logic                valid_d_reg;
    logic [ANGLE_W-1:0]  angle_d_reg;
    logic [ABS_HI_W-1:0] abs_hi_d_reg;

    logic [LED_W-1:0] led_reg;
    logic [LED_W-1:0] led_next;

    logic [MAG_W-1:0]       sample_ext;
    logic [MAG_W-1:0]       mag_raw;
    logic [MAG_W-1:0]       mag;
    logic [ANGLE_W:0]       product;
    logic signed [ANGLE_W:0] sum;
    logic [ANGLE_W-1:0]     abs_angle;
    logic [LEVEL_W-1:0]     lvl;
    logic [LED_W-1:0]       led_set;
    logic [LED_W-1:0]       led_clr;
    logic [LED_W-1:0]       led_new;

    always_comb
    begin
        sample_ext = {sample_a_reg[SAMPLE_W-1], sample_a_reg};
        mag_raw    = sample_a_reg[SAMPLE_W-1] ? (~sample_ext + MAG_W'(1)) : sample_ext;
        mag        = (mag_raw < MAG_W'(cfg.deadband)) ? '0 : mag_raw;
        product    = (ANGLE_W+1)'(mag) * (ANGLE_W+1)'(cfg.step_gain);
    end

    always_comb
    begin
        if (neg_b_reg)
        begin
            sum = {acc_reg[ANGLE_W-1], acc_reg} - $signed({1'b0, delta_b_reg});
        end
        else
        begin
            sum = {acc_reg[ANGLE_W-1], acc_reg} + $signed({1'b0, delta_b_reg});
        end
        // The top two bits disagree only when the sum left the 40-bit range.
        if (sum[ANGLE_W] != sum[ANGLE_W-1])
        begin
            acc_next = sum[ANGLE_W] ? ANGLE_MIN : ANGLE_MAX;
        end
        else
        begin
            acc_next = sum[ANGLE_W-1:0];
        end
    end

    assign abs_angle = acc_reg[ANGLE_W-1] ? (~acc_reg + ANGLE_W'(1)) : acc_reg;

    // The thresholds rise with the level, so the last one met gives the level.
    always_comb
    begin
        lvl = '0;
        for (int k = 1; k <= LEVELS; k++)
        begin
            if (abs_hi_d_reg >= ABS_HI_W'(cfg.level_step) * ABS_HI_W'(k))
            begin
                lvl = LEVEL_W'(k);
            end
        end
        led_set = LED_W'(1) << lvl;
        led_clr = (lvl < LEVEL_W'(LEVELS)) ? (LED_W'(1) << (lvl + LEVEL_W'(1))) : '0;
        led_new = (led_reg | led_set) & ~led_clr;
        led_next = (valid_d_reg && cfg.display_enable) ? led_new : led_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
            acc_reg     <= '0;
            led_reg     <= '0;
        end
        else
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
            valid_d_reg <= valid_c_reg;
            if (valid_b_reg)
            begin
                acc_reg <= acc_next;
            end
            led_reg <= led_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            sample_a_reg <= in_sample;
        end
        neg_b_reg    <= sample_a_reg[SAMPLE_W-1];
        delta_b_reg  <= product[ANGLE_W-1:0];
        angle_d_reg  <= acc_reg;
        abs_hi_d_reg <= abs_angle[ANGLE_W-1:FRAC_W];
    end

    assign out_valid            = valid_d_reg;
    assign out_result.angle     = angle_d_reg;
    assign out_result.bar_level = cfg.display_enable ? lvl : '0;
    assign out_result.led_bar   = cfg.display_enable ? led_new : led_reg;

endmodule
`default_nettype wire

>>> hw/rtl/gri_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Gyro rate integrator result queue
// Small register queue that holds results until the receiver takes them.
// ----------------------------------------------------------------------------
module gri_out_fifo #(
    parameter int DEPTH = gri_pkg::OUT_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire gri_pkg::result_t push_data,
    input  wire logic             pop,
    output logic                  not_empty,
    output gri_pkg::result_t      head_data
);
    import gri_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head_data = mem_reg[rd_ptr_reg];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (count_reg < CNT_W'(DEPTH)))
        else $error("result queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("result queue read while empty");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("result queue pointers differ while empty");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/gyro_rate_integrator_led_bar_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Gyro rate integrator with LED bar
// Integrates gyroscope rate samples into a saturated angle and drives a
// nine-LED level bar.
//
// Samples arrive on the s_axis channel, one 16-bit rate word per
// transaction. Each sample yields one result on the m_axis channel: the
// Q15.24 angle, the bar level and the LED states. The cfg channel writes
// the four registers and is always ready; write it only while no result
// is outstanding.
// A sample passes the sample, product, accumulator and snapshot registers
// and then the result queue, which offers it on m_axis. One sample is
// accepted per cycle while s_axis_tready is high. Up to eight samples may
// be outstanding; the result queue holds them while the receiver stalls,
// and s_axis_tready drops only once eight results are pending. Reset
// clears the angle, turns all LEDs off, empties the queue and loads the
// register defaults.
// ----------------------------------------------------------------------------
module gyro_rate_integrator_led_bar_top #(
    parameter int OUT_DEPTH = gri_pkg::OUT_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [15:0]                     s_axis_tdata,  // rate_sample
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // angle [39:0], bar_level [43:40], led_bar [52:44], zero fill [55:53]
    output logic [gri_pkg::TDATA_W-1:0]          m_axis_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [gri_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gri_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gri_pkg::*;

    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    cfg_t             cfg_reg;
    logic [CNT_W-1:0] outstanding_reg;
    logic             in_accept;
    logic             out_accept;
    logic             core_valid;
    result_t          core_result;
    result_t          head_result;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (outstanding_reg < CNT_W'(OUT_DEPTH));
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_accept    = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.display_enable <= RST_DISPLAY_ENABLE;
            cfg_reg.deadband       <= RST_DEADBAND;
            cfg_reg.step_gain      <= RST_STEP_GAIN;
            cfg_reg.level_step     <= RST_LEVEL_STEP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DISPLAY_ENABLE: cfg_reg.display_enable <= cfg_data[0];
                CFG_DEADBAND:       cfg_reg.deadband       <= cfg_data[DEADBAND_W-1:0];
                CFG_STEP_GAIN:      cfg_reg.step_gain      <= cfg_data[GAIN_W-1:0];
                CFG_LEVEL_STEP:     cfg_reg.level_step     <= cfg_data[STEP_W-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Every accepted transaction reserves a queue slot until its result leaves.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else if (in_accept && !out_accept)
        begin
            outstanding_reg <= outstanding_reg + CNT_W'(1);
        end
        else if (out_accept && !in_accept)
        begin
            outstanding_reg <= outstanding_reg - CNT_W'(1);
        end
    end

    gri_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_accept),
        .in_sample  (s_axis_tdata),
        .out_valid  (core_valid),
        .out_result (core_result)
    );

    gri_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (core_valid),
        .push_data (core_result),
        .pop       (out_accept),
        .not_empty (m_axis_tvalid),
        .head_data (head_result)
    );

    assign m_axis_tdata = TDATA_W'(head_result);

`ifndef SYNTHESIS
    a_outstanding_bound: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= CNT_W'(OUT_DEPTH))
        else $error("more transactions outstanding than queue slots");

    a_valid_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (outstanding_reg != '0))
        else $error("result offered with no transaction outstanding");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (head_result.bar_level <= LEVEL_W'(LEVELS)))
        else $error("bar level above the top level");
`endif

endmodule
`default_nettype wire

>>> sim/gri_angle_monitor.sv
// ----------------------------------------------------------------------------
// Gyro rate integrator angle monitor
// Watches the sample, result and register channels of the integrator, keeps
// its own angle and LED state, and compares every result transaction field
// by field with the reading it predicts.
// ----------------------------------------------------------------------------
module gri_angle_monitor (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    input  wire logic                            s_axis_tready,
    input  wire logic [gri_pkg::SAMPLE_W-1:0]    s_axis_tdata,
    input  wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic [gri_pkg::TDATA_W-1:0]     m_axis_tdata,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [gri_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gri_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                   mismatches,
    output int                                   outstanding,
    output int                                   readings_checked,
    output int                                   saturated_readings
);
    import gri_pkg::*;

    localparam logic signed [ANGLE_W+1:0] ANGLE_TOP    = {3'b000, {(ANGLE_W-1){1'b1}}};
    localparam logic signed [ANGLE_W+1:0] ANGLE_BOTTOM = {3'b111, {(ANGLE_W-1){1'b0}}};

    cfg_t                       regs;
    logic signed [ANGLE_W-1:0]  acc;
    logic [LED_W-1:0]           leds;
    result_t                    due_readings[$];
    int                         errs;
    int                         checked;
    int                         saturated;

    // Advances the angle and the LED bar by one rate sample and returns the
    // reading that the block should report for it.
    function automatic result_t integrate_rate(input logic [SAMPLE_W-1:0] word);
        logic                      neg;
        logic [MAG_W-1:0]          mag;
        logic [ANGLE_W-1:0]        delta;
        logic signed [ANGLE_W+1:0] sum;
        logic [ANGLE_W-1:0]        magnitude;
        logic [ANGLE_W+7:0]        unit;
        logic [LEVEL_W-1:0]        lvl;
        result_t                   r;

        neg = word[SAMPLE_W-1];
        // The most negative word has a magnitude one beyond the positive range.
        mag = neg ? 17'h08000 - {2'b00, word[SAMPLE_W-2:0]} : {1'b0, word};
        if (mag < MAG_W'(regs.deadband))
            mag = '0;
        delta = ANGLE_W'(mag) * ANGLE_W'(regs.step_gain);
        sum   = (ANGLE_W+2)'(acc);
        sum   = neg ? sum - $signed({2'b00, delta}) : sum + $signed({2'b00, delta});
        if (sum > ANGLE_TOP)
            sum = ANGLE_TOP;
        if (sum < ANGLE_BOTTOM)
            sum = ANGLE_BOTTOM;
        acc = sum[ANGLE_W-1:0];

        lvl = '0;
        if (regs.display_enable) begin
            magnitude = acc[ANGLE_W-1] ? -acc : acc;
            unit      = {{(ANGLE_W+8-STEP_W-FRAC_W){1'b0}}, regs.level_step, {FRAC_W{1'b0}}};
            for (int k = 1; k <= LEVELS; k++) begin
                if ({8'b0, magnitude} >= unit * (ANGLE_W+8)'(k))
                    lvl = LEVEL_W'(k);
            end
            leds[lvl] = 1'b1;
            if (lvl < LEVEL_W'(LEVELS))
                leds[lvl + LEVEL_W'(1)] = 1'b0;
        end

        r.angle     = acc;
        r.bar_level = lvl;
        r.led_bar   = leds;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;

        if (!rst_n)
        begin
            regs = '{display_enable: RST_DISPLAY_ENABLE, deadband: RST_DEADBAND,
                     step_gain: RST_STEP_GAIN, level_step: RST_LEVEL_STEP};
            acc       = '0;
            leds      = '0;
            errs      = 0;
            checked   = 0;
            saturated = 0;
            due_readings.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_DISPLAY_ENABLE: regs.display_enable = cfg_data[0];
                    CFG_DEADBAND:       regs.deadband       = cfg_data[DEADBAND_W-1:0];
                    CFG_STEP_GAIN:      regs.step_gain      = cfg_data[GAIN_W-1:0];
                    CFG_LEVEL_STEP:     regs.level_step     = cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata[RESULT_W-1:0]);
                if (due_readings.size() == 0)
                begin
                    errs++;
                    $display("%0t: result %h arrived with none expected", $time, m_axis_tdata);
                end
                else
                begin
                    want = due_readings.pop_front();
                    checked++;
                    if (got.angle != want.angle)
                    begin
                        errs++;
                        $display("%0t: angle expected %h, got %h", $time, want.angle, got.angle);
                    end
                    if (got.bar_level != want.bar_level)
                    begin
                        errs++;
                        $display("%0t: bar_level expected %0d, got %0d", $time,
                                 want.bar_level, got.bar_level);
                    end
                    if (got.led_bar != want.led_bar)
                    begin
                        errs++;
                        $display("%0t: led_bar expected %b, got %b", $time,
                                 want.led_bar, got.led_bar);
                    end
                    if (m_axis_tdata[TDATA_W-1:RESULT_W] != '0)
                    begin
                        errs++;
                        $display("%0t: fill bits expected 0, got %b", $time,
                                 m_axis_tdata[TDATA_W-1:RESULT_W]);
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                want = integrate_rate(s_axis_tdata);
                if (want.angle == ANGLE_TOP[ANGLE_W-1:0] ||
                    want.angle == ANGLE_BOTTOM[ANGLE_W-1:0])
                    saturated++;
                due_readings.push_back(want);
            end
        end

        mismatches         <= errs;
        outstanding        <= due_readings.size();
        readings_checked   <= checked;
        saturated_readings <= saturated;
    end

endmodule

>>> sim/gyro_rate_integrator_led_bar_top_tb.sv
// ----------------------------------------------------------------------------
// Gyro rate integrator with LED bar testbench
// Drives rate samples and register writes into the integrator with random
// idling on the sample and result channels, and leaves prediction and
// comparison of every result to the angle monitor beside it.
// ----------------------------------------------------------------------------
module gyro_rate_integrator_led_bar_top_tb;
    import gri_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 160;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [SAMPLE_W-1:0]    s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [TDATA_W-1:0]     m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int mismatches;
    int outstanding;
    int readings_checked;
    int saturated_readings;
    int cycles          = 0;
    int samples_sent    = 0;
    int settings_loaded = 0;
    bit quiet           = 1'b0;

    gyro_rate_integrator_led_bar_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    gri_angle_monitor i_monitor (
        .clk                (clk),
        .rst_n              (rst_n),
        .s_axis_tvalid      (s_axis_tvalid),
        .s_axis_tready      (s_axis_tready),
        .s_axis_tdata       (s_axis_tdata),
        .m_axis_tvalid      (m_axis_tvalid),
        .m_axis_tready      (m_axis_tready),
        .m_axis_tdata       (m_axis_tdata),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .mismatches         (mismatches),
        .outstanding        (outstanding),
        .readings_checked   (readings_checked),
        .saturated_readings (saturated_readings)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("gyro_rate_integrator_led_bar_top: mismatch");
            $finish;
        end
    end

    // Result side: stalls at random unless a quiet stretch is running.
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            m_axis_tready <= rst_n && (quiet || $urandom_range(99) >= 15);
        end
    end

    task automatic send_rate(input logic [SAMPLE_W-1:0] word);
        while (!quiet && $urandom_range(99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge clk); while (!s_axis_tready);
        samples_sent++;
    endtask

    // Holds the samples back until every reading is in and the pipeline is empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // The narrow registers get random upper bits, which the block must drop.
    task automatic load_regs(input cfg_t c);
        logic [CFG_DATA_W-1:0] junk;

        junk = CFG_DATA_W'($urandom);
        settle();
        put_reg(CFG_DISPLAY_ENABLE, {junk[CFG_DATA_W-1:1], c.display_enable});
        put_reg(CFG_DEADBAND, {junk[CFG_DATA_W-1:DEADBAND_W], c.deadband});
        put_reg(CFG_STEP_GAIN, c.step_gain);
        put_reg(CFG_LEVEL_STEP, {junk[CFG_DATA_W-1:STEP_W], c.level_step});
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    function automatic cfg_t pick_setting(input int phase);
        cfg_t c;

        c.display_enable = (phase % 4 != 3);
        case (phase % 3)
            0:       c.deadband = 8'd0;
            1:       c.deadband = 8'd255;
            default: c.deadband = DEADBAND_W'($urandom);
        endcase
        case (phase % 6)
            0:       c.step_gain = 24'hFFFFFF;
            1:       c.step_gain = 24'd0;
            2:       c.step_gain = GAIN_W'($urandom);
            default: c.step_gain = GAIN_W'($urandom_range(30000, 500));
        endcase
        case (phase % 5)
            0:       c.level_step = 5'd1;
            1:       c.level_step = 5'd31;
            2:       c.level_step = 5'd0;
            default: c.level_step = STEP_W'($urandom_range(31, 1));
        endcase
        return c;
    endfunction

    // Runs of same-signed rates swing the angle up and down through the bar
    // levels; a few words of any sign are mixed in as noise.
    task automatic swing(input int count);
        int                  run_left;
        int                  m;
        int                  kind;
        logic                down;
        logic [SAMPLE_W-1:0] w;

        run_left = 0;
        down     = 1'b0;
        repeat (count)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(24, 1);
                down     = 1'($urandom_range(1));
            end
            run_left--;
            kind = $urandom_range(9);
            m    = (kind == 2) ? $urandom_range(300) : $urandom_range(32767);
            w    = m[SAMPLE_W-1:0];
            if (down)
                w = -w;
            if (kind == 0)
                w = SAMPLE_W'($urandom);
            else if (kind == 1)
                w = down ? 16'h8000 : 16'h7FFF;
            send_rate(w);
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_DISPLAY_ENABLE;
        cfg_data      <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: display off, so the bar must stay dark.
        send_rate(16'h7FFF);
        send_rate(16'h0009);
        send_rate(16'h000A);

        // Display on at the default scaling: climb to the top level and back
        // down through zero, with samples either side of the deadband.
        load_regs('{display_enable: 1'b1, deadband: 8'd10, step_gain: 24'd23488,
                    level_step: 5'd10});
        send_rate(16'h0000);
        send_rate(16'h0009);
        send_rate(16'h000A);
        send_rate(16'hFFF6);
        send_rate(16'hFFF7);
        repeat (4) send_rate(16'h7FFF);
        repeat (8) send_rate(16'h8000);

        // Full gain saturates the angle at both ends in a couple of samples.
        load_regs('{display_enable: 1'b1, deadband: 8'd0, step_gain: 24'hFFFFFF,
                    level_step: 5'd31});
        send_rate(16'h7FFF);
        send_rate(16'h7FFF);
        repeat (3) send_rate(16'h8000);
        send_rate(16'h0001);

        for (int p = 0; p < PHASES; p++)
        begin
            load_regs(pick_setting(p));
            quiet = (p == 2);
            swing(PHASE_ITEMS);
        end
        quiet = 1'b0;

        settle();
        $display("Sent %0d rate samples under %0d register settings.",
                 samples_sent, settings_loaded);
        $display("Checked %0d readings, %0d of them held at the angle limit.",
                 readings_checked, saturated_readings);
        if (mismatches == 0)
            $display("gyro_rate_integrator_led_bar_top: match");
        else
            $display("gyro_rate_integrator_led_bar_top: mismatch");
        $finish;
    end

endmodule
